// ----- rtl/core/jep_pkg.sv -----
// ----------------------------------------------------------------------------
// jep_pkg
// Shared port widths and register map of the Josephus elimination block.
// ----------------------------------------------------------------------------
`default_nettype none

package jep_pkg;

    localparam int KEY_PORT_W    = 16;
    localparam int POS_PORT_W    = 7;
    localparam int FIRST_COUNT_W = 16;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 3;
    localparam int REG_IDX_W     = 1;

    localparam logic [REG_IDX_W-1:0] REG_FIRST_COUNT = 1'b0;

endpackage

`default_nettype wire

// ----- rtl/core/jep_mod.sv -----
// ----------------------------------------------------------------------------
// jep_mod
// Iterative remainder unit: one restoring bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jep_mod #(
    parameter int KEY_BITS = 16,
    parameter int CNT_W    = 7
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [KEY_BITS-1:0] dividend,
    input  wire logic [CNT_W-1:0]    divisor,
    output logic                     done,
    output logic [CNT_W-1:0]         remainder
);

    localparam int ITER_W = $clog2(KEY_BITS + 1);
    localparam logic [ITER_W-1:0] ITER_INIT = ITER_W'(KEY_BITS);
    localparam logic [ITER_W-1:0] ITER_ONE  = ITER_W'(1);

    logic                busy_reg;
    logic                done_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic [KEY_BITS-1:0] sh_reg;
    logic [CNT_W-1:0]    div_reg;
    logic [CNT_W-1:0]    rem_reg;

    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic [CNT_W-1:0]    rem_next;

    always_comb begin
        trial = {rem_reg, sh_reg[KEY_BITS-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = diff[CNT_W-1:0];
        end else begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_INIT;
            end else if (busy_reg) begin
                iter_reg <= iter_reg - ITER_ONE;
                if (iter_reg == ITER_ONE) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            sh_reg  <= {sh_reg[KEY_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/josephus_elimination_order.sv -----
// ----------------------------------------------------------------------------
// josephus_elimination_order
// Password Josephus ring: loads keys, then emits the full removal order.
// ----------------------------------------------------------------------------
// Input channel (s_*): one request per person, in ring order. A request
// without s_last_person stores its key. Keys beyond
// MAX_PEOPLE are dropped. The request with s_last_person closes the ring.
// Output channel (m_*): one request per removal, m_last_removed on the last.
// Each removal walks to the next living person, reduces the current step
// value modulo the living count in the bit-serial remainder unit, walks
// along the living positions to the counted one, removes that person and
// reads the removed person's key from the key memory. The walk over the
// alive mask and the remainder unit set the time per removal. s_ready stays
// low from the last key until the final removal has been placed in the
// output register.
// A finished removal waits in the output register while the next one is
// computed; the block stalls only when a second removal is ready and m_ready
// is still low. Reset clears the ring and sets first_count to 1; the key
// memory is not cleared. first_count is written through the APB port at
// address 0; the user must do so only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module josephus_elimination_order
    import jep_pkg::*;
#(
    parameter int MAX_PEOPLE = 64,
    parameter int KEY_BITS   = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [KEY_PORT_W-1:0] s_person_key,
    input  wire logic                  s_last_person,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [POS_PORT_W-1:0]      m_removed_person,
    output logic                       m_last_removed
);

    localparam int IDX_W = $clog2(MAX_PEOPLE);
    localparam int CNT_W = $clog2(MAX_PEOPLE + 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PEOPLE);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_PEOPLE - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_MOD,
        ST_WALK,
        ST_KEY
    } state_t;

    state_t                   state_reg, state_next;
    logic [FIRST_COUNT_W-1:0] first_count_reg;
    logic [CNT_W-1:0]         loaded_reg, loaded_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [KEY_BITS-1:0]      step_reg, step_next;
    logic [MAX_PEOPLE-1:0]    alive_reg, alive_next;
    logic                     m_valid_reg, m_valid_next;
    logic [POS_PORT_W-1:0]    m_pos_reg, m_pos_next;
    logic                     m_last_reg, m_last_next;

    logic [KEY_BITS-1:0]      key_mem [MAX_PEOPLE];
    logic [KEY_BITS-1:0]      rd_data_reg;
    logic                     mem_we;

    logic [31:0]              key_wide;
    logic [31:0]              fc_wide;
    logic [CNT_W-1:0]         loaded_new;
    logic [IDX_W-1:0]         pos_inc;
    logic                     out_free;
    logic                     div_start;
    logic                     div_done;
    logic [CNT_W-1:0]         div_rem;
    logic [CNT_W-1:0]         count_x;
    logic [REG_IDX_W-1:0]     reg_idx;
    logic                     cfg_we;

    assign key_wide   = 32'(s_person_key);
    assign fc_wide    = 32'(first_count_reg);
    assign loaded_new = (loaded_reg < MAX_CNT) ? loaded_reg + CNT_ONE : loaded_reg;
    assign pos_inc    = (pos_reg == LAST_POS) ? '0 : pos_reg + IDX_W'(1);
    assign out_free   = !m_valid_reg || m_ready;
    assign count_x    = (div_rem == '0) ? rem_reg : div_rem;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_FIRST_COUNT);
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_FIRST_COUNT) ? CFG_DATA_W'(first_count_reg) : '0;

    jep_mod #(
        .KEY_BITS (KEY_BITS),
        .CNT_W    (CNT_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (step_reg),
        .divisor   (rem_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        state_next   = state_reg;
        loaded_next  = loaded_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        step_next    = step_reg;
        alive_next   = alive_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_pos_next   = m_pos_reg;
        m_last_next  = m_last_reg;
        mem_we       = 1'b0;
        div_start    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mem_we      = (loaded_reg < MAX_CNT);
                    loaded_next = loaded_new;
                    if (s_last_person) begin
                        for (int i = 0; i < MAX_PEOPLE; i++) begin
                            alive_next[i] = (CNT_W'(i) < loaded_new);
                        end
                        rem_next   = loaded_new;
                        pos_next   = '0;
                        step_next  = fc_wide[KEY_BITS-1:0];
                        state_next = ST_SEEK;
                    end
                end
            end
            ST_SEEK: begin
                if (alive_reg[pos_reg]) begin
                    div_start  = 1'b1;
                    state_next = ST_MOD;
                end else begin
                    pos_next = pos_inc;
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    cnt_next   = count_x - CNT_ONE;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (cnt_reg != '0) begin
                    pos_next = pos_inc;
                    if (alive_reg[pos_inc]) begin
                        cnt_next = cnt_reg - CNT_ONE;
                    end
                end else if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_pos_next          = POS_PORT_W'(pos_reg) + POS_PORT_W'(1);
                    m_last_next         = (rem_reg == CNT_ONE);
                    alive_next[pos_reg] = 1'b0;
                    rem_next            = rem_reg - CNT_ONE;
                    if (rem_reg == CNT_ONE) begin
                        loaded_next = '0;
                        alive_next  = '0;
                        pos_next    = '0;
                        step_next   = '0;
                        state_next  = ST_IDLE;
                    end else begin
                        state_next = ST_KEY;
                    end
                end
            end
            ST_KEY: begin
                step_next  = rd_data_reg;
                pos_next   = pos_inc;
                state_next = ST_SEEK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            first_count_reg <= FIRST_COUNT_W'(1);
            loaded_reg      <= '0;
            rem_reg         <= '0;
            cnt_reg         <= '0;
            pos_reg         <= '0;
            step_reg        <= '0;
            alive_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            loaded_reg  <= loaded_next;
            rem_reg     <= rem_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            step_reg    <= step_next;
            alive_reg   <= alive_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                first_count_reg <= pwdata[FIRST_COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_pos_reg  <= m_pos_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[loaded_reg[IDX_W-1:0]] <= key_wide[KEY_BITS-1:0];
        end
        rd_data_reg <= key_mem[pos_reg];
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_removed_person = m_pos_reg;
    assign m_last_removed   = m_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/jep_checker.sv -----
// ----------------------------------------------------------------------------
// jep_checker
// Port-level checks of the Josephus elimination block.
// ----------------------------------------------------------------------------
`default_nettype none

module jep_checker
    import jep_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  s_last_person,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [POS_PORT_W-1:0] m_removed_person,
    input wire logic                  m_last_removed
);

    // closing the ring blocks further input
    a_ring_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_person |=> !s_ready)
        else $error("input accepted right after ring close");

    // final removal leaves nothing pending
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_removed |=> !m_valid)
        else $error("result after final removal");

    a_pos_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_removed_person != '0)
        else $error("removed position is zero");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_removed_person)
            && $stable(m_last_removed))
        else $error("stalled result changed");

endmodule

bind josephus_elimination_order jep_checker u_jep_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_last_person    (s_last_person),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_removed_person (m_removed_person),
    .m_last_removed   (m_last_removed)
);

`default_nettype wire
